/* rtl/ppph_pkg.sv */
// ----------------------------------------------------------------------------
// PPP header receiver package
// Shared types, codes and the byte-wide FCS-16 update.
// ----------------------------------------------------------------------------
package ppph_pkg;

	localparam logic [15:0] FCS_INIT  = 16'hFFFF;
	localparam logic [15:0] FCS_POLY  = 16'h8408;
	localparam logic [7:0]  BYTE_ESC  = 8'h7D;
	localparam logic [7:0]  BYTE_FLAG = 8'h7E;
	localparam logic [7:0]  BYTE_ADDR = 8'hFF;
	localparam logic [7:0]  BYTE_CTRL = 8'h03;
	localparam logic [7:0]  ESC_XOR   = 8'h20;

	localparam logic [1:0] CFG_ACCM = 2'd0;
	localparam logic [1:0] CFG_ACFC = 2'd1;
	localparam logic [1:0] CFG_PFC  = 2'd2;

	typedef enum logic [2:0] {
		EV_CONSUMED = 3'd0,
		EV_DROPPED  = 3'd1,
		EV_ESCAPE   = 3'd2,
		EV_RESTART  = 3'd3,
		EV_DONE     = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		PG_NONE  = 2'd0,
		PG_ADDR  = 2'd1,
		PG_CTRL  = 2'd2,
		PG_PROTO = 2'd3
	} prog_t;

	typedef struct packed {
		logic [31:0] accm;
		logic        acfc;
		logic        pfc;
	} cfg_t;

	typedef struct packed {
		event_t      ev;
		logic [15:0] proto;
		logic [15:0] fcs;
	} res_t;

	function automatic logic [15:0] fcs_add(input logic [15:0] f, input logic [7:0] b);
		logic [15:0] v;
		v = f ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (v[0])
				v = (v >> 1) ^ FCS_POLY;
			else
				v = v >> 1;
		end
		return v;
	endfunction

endpackage

/* rtl/ppph_cfg.sv */
// ----------------------------------------------------------------------------
// PPP header receiver configuration registers
// Holds the receive ACCM and the ACFC and PFC enables.
// ----------------------------------------------------------------------------
module ppph_cfg import ppph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accm <= 32'hFFFF_FFFF;
			cfg_q.acfc <= 1'b0;
			cfg_q.pfc  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCM: cfg_q.accm <= cfg_data;
				CFG_ACFC: cfg_q.acfc <= cfg_data[0];
				CFG_PFC:  cfg_q.pfc  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/ppph_track.sv */
// ----------------------------------------------------------------------------
// PPP header tracker
// Decodes one raw byte against the header state and updates the FCS.
// ----------------------------------------------------------------------------
module ppph_track import ppph_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  logic [7:0] raw,
	output res_t       res
);

	prog_t       prog_q, prog_d;
	logic        esc_q, esc_d;
	logic [7:0]  phigh_q, phigh_d;
	logic [15:0] fcs_q, fcs_d;

	logic        drop, is_data;
	logic [7:0]  b;
	event_t      ev;
	logic        do_restart, do_crc, ld_high, short_pfc;
	prog_t       prog_n;

	// classify the word
	always_comb begin
		drop       = (raw[7:5] == 3'b000) && cfg.accm[raw[4:0]];
		is_data    = !drop && (esc_q || (raw != BYTE_ESC && raw != BYTE_FLAG));
		b          = esc_q ? (raw ^ ESC_XOR) : raw;
		ev         = EV_CONSUMED;
		do_restart = 1'b0;
		do_crc     = 1'b0;
		ld_high    = 1'b0;
		short_pfc  = 1'b0;
		prog_n     = prog_q;
		if (drop) begin
			ev = EV_DROPPED;
		end else if (!is_data) begin
			if (raw == BYTE_ESC) begin
				ev = EV_ESCAPE;
			end else begin
				ev         = EV_RESTART;
				do_restart = 1'b1;
			end
		end else if (prog_q == PG_NONE || prog_q == PG_ADDR) begin
			if (b == BYTE_ADDR) begin
				if (prog_q == PG_NONE) begin
					prog_n = PG_ADDR;
					do_crc = 1'b1;
				end else begin
					ev         = EV_RESTART;
					do_restart = 1'b1;
				end
			end else if (b == BYTE_CTRL) begin
				if (prog_q == PG_ADDR) begin
					prog_n = PG_CTRL;
					do_crc = 1'b1;
				end else begin
					ev         = EV_RESTART;
					do_restart = 1'b1;
				end
			end else if (cfg.acfc && prog_q == PG_NONE) begin
				do_crc = 1'b1;
				if (cfg.pfc && b[0]) begin
					short_pfc = 1'b1;
					ev        = EV_DONE;
					prog_n    = PG_NONE;
				end else begin
					ld_high = 1'b1;
					prog_n  = PG_PROTO;
				end
			end else begin
				ev         = EV_RESTART;
				do_restart = 1'b1;
			end
		end else begin
			do_crc = 1'b1;
			if (prog_q == PG_CTRL && !(cfg.pfc && b[0])) begin
				ld_high = 1'b1;
				prog_n  = PG_PROTO;
			end else begin
				short_pfc = (prog_q == PG_CTRL);
				ev        = EV_DONE;
				prog_n    = PG_NONE;
			end
		end
	end

	// next state
	always_comb begin
		prog_d  = do_restart ? PG_NONE : prog_n;
		esc_d   = drop ? esc_q : (esc_q ? 1'b0 : (raw == BYTE_ESC));
		phigh_d = phigh_q;
		if (ld_high)
			phigh_d = b;
		else if (short_pfc)
			phigh_d = 8'h00;
		if (do_restart)
			fcs_d = FCS_INIT;
		else if (do_crc)
			fcs_d = fcs_add(fcs_q, b);
		else
			fcs_d = fcs_q;
	end

	// result word
	always_comb begin
		res.ev    = ev;
		res.fcs   = fcs_d;
		res.proto = 16'h0000;
		if (ev == EV_DONE)
			res.proto = {(short_pfc ? 8'h00 : phigh_q), b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q  <= PG_NONE;
			esc_q   <= 1'b0;
			phigh_q <= 8'h00;
			fcs_q   <= FCS_INIT;
		end else if (take) begin
			prog_q  <= prog_d;
			esc_q   <= esc_d;
			phigh_q <= phigh_d;
			fcs_q   <= fcs_d;
		end
	end

`ifndef SYNTHESIS
	a_restart_fcs: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.ev == EV_RESTART |=> fcs_q == FCS_INIT && prog_q == PG_NONE)
		else $error("restart did not reload header state");
	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		take && drop |=> $stable(fcs_q) && $stable(esc_q) && $stable(prog_q))
		else $error("dropped word changed state");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.ev == EV_DONE |=> prog_q == PG_NONE && !esc_q)
		else $error("header completion left state behind");
`endif

endmodule

/* rtl/ppp_header_receiver.sv */
// ----------------------------------------------------------------------------
// PPP header receiver
// Tracks the async HDLC framed PPP header one raw line byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: in_valid/in_stall carry rx_byte, one raw serial-line byte.
//   out channel: out_valid/out_stall carry one result word per input word:
//   event_res, protocol_value (nonzero only on header complete) and
//   fcs_value, the running FCS-16 after the byte.
//   cfg port: cfg_we writes cfg_data into register cfg_index
//   (0 ACCM, 1 ACFC enable, 2 PFC enable); write only while idle.
// Pipeline: a word is registered on input, decoded against the header
//   state and registered on output. Throughput is one word per cycle
//   while the output is not stalled; the header state and the byte-wide
//   FCS update are computed combinationally in the decode stage.
// Reset: both stages empty, no header in progress, no escape pending,
//   FCS 0xFFFF, ACCM all ones, ACFC and PFC off.
// Stall: a held output word stays stable; the input stage then fills
//   and in_stall rises in the same cycle that both stages are occupied.
// ----------------------------------------------------------------------------
module ppp_header_receiver import ppph_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [15:0] protocol_value,
	output logic [15:0] fcs_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1, valid_s2;
	logic [7:0] byte_s1;
	res_t       res_s2;
	logic       adv;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	ppph_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppph_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.take   (valid_s1 && adv),
		.raw    (byte_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1)
			res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign event_res      = res_s2.ev;
	assign protocol_value = res_s2.proto;
	assign fcs_value      = res_s2.fcs;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");
	a_proto_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.ev != EV_DONE |-> protocol_value == 16'h0000)
		else $error("protocol reported without header completion");
	a_restart_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.ev == EV_RESTART |-> fcs_value == FCS_INIT)
		else $error("restart word carries a stale FCS");
`endif

endmodule

/* verif/ppp_header_receiver_test.sv */
// ----------------------------------------------------------------------------
// PPP header receiver testbench
// Drives raw line bytes through ppp_header_receiver and checks every result
// word (event, protocol, running FCS) against a cycle-free header tracker.
// Directed bytes cover the map, escape, flag and compression cases; random
// framed traffic with noise runs under several register settings, random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module ppp_header_receiver_test import ppph_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [15:0] protocol_value;
	logic [15:0] fcs_value;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_ACCM;
	logic [31:0] cfg_data = 32'h0;

	logic [31:0] map_bits = 32'hFFFF_FFFF;
	logic        acfc_on = 1'b0;
	logic        pfc_on = 1'b0;
	prog_t       hdr_prog = PG_NONE;
	logic        esc_armed = 1'b0;
	logic [7:0]  proto_hi = 8'h00;
	logic [15:0] fcs_acc = FCS_INIT;

	res_t header_results [$];
	res_t want_word;
	int   errors = 0;
	int   words_sent = 0;
	int   cycles = 0;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   hold_left = 0;
	logic calm = 1'b0;

	ppp_header_receiver i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.protocol_value (protocol_value),
		.fcs_value      (fcs_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = {1'b0, r[15:1]};
			if (fb)
				r = r ^ FCS_POLY;
		end
		return r;
	endfunction

	function automatic res_t track_header(input logic [7:0] raw);
		res_t       r;
		logic [7:0] d;
		logic       is_data;
		logic       first;
		r.ev = EV_CONSUMED;
		r.proto = 16'h0000;
		is_data = 1'b0;
		d = raw;
		if (raw < 8'd32 && map_bits[raw[4:0]]) begin
			r.ev = EV_DROPPED;
		end else if (esc_armed) begin
			esc_armed = 1'b0;
			d = raw ^ ESC_XOR;
			is_data = 1'b1;
		end else if (raw == BYTE_ESC) begin
			esc_armed = 1'b1;
			r.ev = EV_ESCAPE;
		end else if (raw == BYTE_FLAG) begin
			r.ev = EV_RESTART;
		end else begin
			is_data = 1'b1;
		end
		if (is_data) begin
			if (hdr_prog == PG_NONE && d == BYTE_ADDR) begin
				hdr_prog = PG_ADDR;
				fcs_acc = crc16_step(fcs_acc, d);
			end else if (hdr_prog == PG_ADDR && d == BYTE_CTRL) begin
				hdr_prog = PG_CTRL;
				fcs_acc = crc16_step(fcs_acc, d);
			end else if (hdr_prog == PG_CTRL || hdr_prog == PG_PROTO ||
					(acfc_on && hdr_prog == PG_NONE && d != BYTE_CTRL)) begin
				first = (hdr_prog != PG_PROTO);
				fcs_acc = crc16_step(fcs_acc, d);
				if (first && !(pfc_on && d[0])) begin
					proto_hi = d;
					hdr_prog = PG_PROTO;
				end else begin
					if (first)
						proto_hi = 8'h00;
					r.ev = EV_DONE;
					r.proto = {proto_hi, d};
					hdr_prog = PG_NONE;
				end
			end else begin
				r.ev = EV_RESTART;
			end
		end
		if (r.ev == EV_RESTART) begin
			hdr_prog = PG_NONE;
			fcs_acc = FCS_INIT;
		end
		r.fcs = fcs_acc;
		return r;
	endfunction

	task automatic report_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (header_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got ev %0d proto %h fcs %h",
					$time, event_res, protocol_value, fcs_value);
			end else begin
				want_word = header_results.pop_front();
				if (event_res !== want_word.ev)
					report_field("event_res", 16'(want_word.ev), 16'(event_res));
				if (protocol_value !== want_word.proto)
					report_field("protocol_value", want_word.proto, protocol_value);
				if (fcs_value !== want_word.fcs)
					report_field("fcs_value", want_word.fcs, fcs_value);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 7);
	end

	task automatic send_word(input logic [7:0] b);
		if (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		header_results.push_back(track_header(b));
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (header_results.size() != 0);
	endtask

	task automatic set_config(input logic [31:0] accm, input logic acfc, input logic pfc);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACCM;
		cfg_data <= accm;
		@(posedge clk);
		cfg_index <= CFG_ACFC;
		cfg_data <= {31'd0, acfc};
		@(posedge clk);
		cfg_index <= CFG_PFC;
		cfg_data <= {31'd0, pfc};
		@(posedge clk);
		cfg_we <= 1'b0;
		map_bits = accm;
		acfc_on = acfc;
		pfc_on = pfc;
	endtask

	task automatic send_data(input logic [7:0] d);
		logic [7:0] stray;
		if ($urandom_range(19) == 0) begin
			stray = 8'($urandom_range(31));
			send_word(stray);
		end
		if (d == BYTE_ESC || d == BYTE_FLAG || (d < 8'd32 && map_bits[d[4:0]]) ||
				$urandom_range(15) == 0) begin
			send_word(BYTE_ESC);
			send_word(d ^ ESC_XOR);
		end else begin
			send_word(d);
		end
	endtask

	task automatic send_frame();
		int         kind;
		logic [7:0] hi;
		logic [7:0] lo;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8)) begin
				lo = 8'($urandom_range(255));
				send_word(lo);
			end
			return;
		end
		send_word(BYTE_FLAG);
		if (!acfc_on || $urandom_range(1)) begin
			send_data(BYTE_ADDR);
			if (kind >= 15)
				send_data(BYTE_CTRL);
		end
		hi = 8'($urandom_range(255));
		if (pfc_on && $urandom_range(1)) begin
			hi[0] = 1'b1;
			send_data(hi);
		end else begin
			hi[0] = ($urandom_range(9) == 0);
			lo = 8'($urandom_range(255));
			send_data(hi);
			send_data(lo);
		end
		repeat ($urandom_range(0, 6)) begin
			lo = 8'($urandom_range(255));
			send_data(lo);
		end
		if ($urandom_range(19) == 0)
			drain();
	endtask

	task automatic test_default_config();
		logic [7:0] seq [16];
		seq = '{8'h00, 8'h1F, BYTE_FLAG, BYTE_ADDR, BYTE_CTRL, 8'h00, 8'h21, BYTE_ESC,
			8'h05, 8'h5E, BYTE_ADDR, BYTE_ADDR, BYTE_CTRL, BYTE_ESC, 8'h5D, 8'h80};
		foreach (seq[i])
			send_word(seq[i]);
	endtask

	task automatic test_compression();
		logic [7:0] seq [11];
		set_config(32'h0000_0000, 1'b1, 1'b1);
		seq = '{8'h00, 8'h21, 8'h1F, BYTE_ADDR, BYTE_CTRL, 8'hC0, 8'h21, BYTE_ESC, 8'h5E,
			BYTE_ESC, 8'h5D};
		foreach (seq[i])
			send_word(seq[i]);
	endtask

	task automatic test_random_frames();
		int goal;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(32'hFFFF_FFFF, 1'b0, 1'b0);
				1: set_config(32'h0000_0000, 1'b1, 1'b1);
				2: set_config($urandom, 1'b1, 1'b0);
				3: set_config($urandom, 1'b0, 1'b1);
				4: set_config(32'h000A_0000, 1'b1, 1'b1);
				default: set_config(32'hFFFF_FFFF, 1'b1, 1'b1);
			endcase
			calm <= (ph == 3);
			goal = words_sent + 130;
			while (words_sent < goal)
				send_frame();
		end
		calm <= 1'b0;
	endtask

	task automatic test_hold_off();
		set_config($urandom, 1'b0, 1'b0);
		holds_asked <= holds_asked + 1;
		repeat (12) begin
			send_word(BYTE_FLAG);
			send_data(BYTE_ADDR);
			send_data(BYTE_CTRL);
			send_data(8'h00);
			send_data(8'h21);
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_compression();
		test_random_frames();
		test_hold_off();
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
rtl/ppph_pkg.sv
rtl/ppph_cfg.sv
rtl/ppph_track.sv
rtl/ppp_header_receiver.sv
verif/ppp_header_receiver_test.sv
